@@ rtl/jacobi_five_point_stencil_unit_defines.svh @@
// Assertion macros for the stencil RTL; used by jfps_out.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef JACOBI_FIVE_POINT_STENCIL_UNIT_DEFINES_SVH
`define JACOBI_FIVE_POINT_STENCIL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define JFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define JFPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JFPS_ASSERT(lbl, prop, msg)
`define JFPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/jfps_pkg.sv @@
// Shared types and constants of the five-point stencil unit.
// No dependencies.
`default_nettype none
package jfps_pkg;
  localparam int MAX_COLS  = 1024;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = 16;
  localparam int CNT_COL_W = 11;
  localparam int SAMPLE_W  = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  localparam logic [ROW_W-1:0]     ROWS_RESET = 16'd256;
  localparam logic [CNT_COL_W-1:0] COLS_RESET = 11'd256;
  localparam logic [ROW_W-1:0]     ROWS_MIN   = 16'd3;
  localparam logic [CNT_COL_W-1:0] COLS_MIN   = 11'd3;
  localparam logic [CNT_COL_W-1:0] COLS_MAX   = 11'd1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Position of an accepted item and what it produces.
  typedef struct packed {
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
  } pos_t;

  typedef struct packed {
    sample_t          sample;
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
  } stage_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    sample_t top;
  } nbr_t;
endpackage
`default_nettype wire

@@ rtl/jfps_in_if.sv @@
// Input stream channel of the stencil unit: grid points with start marker.
// Depends on jfps_pkg.
`default_nettype none
interface jfps_in_if;
  import jfps_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    grid_start;
  modport source(output valid, sample, grid_start, input ready);
  modport sink(input valid, sample, grid_start, output ready);
endinterface
`default_nettype wire

@@ rtl/jfps_out_if.sv @@
// Result stream channel of the stencil unit: updated interior points.
// Depends on jfps_pkg.
`default_nettype none
interface jfps_out_if;
  import jfps_pkg::*;
  logic                    valid;
  logic                    ready;
  sample_t                 new_value;
  logic [ROW_W-1:0]        point_row;
  logic [COL_W-1:0]        point_col;
  logic                    last_point;
  modport source(output valid, new_value, point_row, point_col, last_point, input ready);
  modport sink(input valid, new_value, point_row, point_col, last_point, output ready);
endinterface
`default_nettype wire

@@ rtl/jfps_pos.sv @@
// Grid size registers and raster position counters; classifies each item.
// Depends on jfps_pkg.
`default_nettype none
module jfps_pos (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [jfps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jfps_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           accept,
  input  wire logic                           grid_start,
  output jfps_pkg::pos_t                      pos
);
  import jfps_pkg::*;

  logic [ROW_W-1:0]     grid_rows_r;
  logic [CNT_COL_W-1:0] grid_cols_r;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;

  logic [ROW_W-1:0]     rows_eff;
  logic [CNT_COL_W-1:0] cols_eff;
  logic [ROW_W-1:0]     r;
  logic [COL_W-1:0]     c;
  logic [CNT_COL_W-1:0] c_ext;
  logic [CNT_COL_W-1:0] c_inc;
  logic [ROW_W:0]       r_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_RESET;
      grid_cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data[ROW_W-1:0];
        REG_GRID_COLS: grid_cols_r <= cfg_data[CNT_COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (grid_rows_r < ROWS_MIN) ? ROWS_MIN : grid_rows_r;
    if (grid_cols_r < COLS_MIN) begin
      cols_eff = COLS_MIN;
    end else if (grid_cols_r > COLS_MAX) begin
      cols_eff = COLS_MAX;
    end else begin
      cols_eff = grid_cols_r;
    end

    r     = grid_start ? '0 : row_r;
    c     = grid_start ? '0 : col_r;
    c_ext = {1'b0, c};
    c_inc = c_ext + 11'd1;
    r_inc = {1'b0, r} + 17'd1;

    pos.point_row = r - 16'd1;
    pos.col       = c;
    pos.emit      = (r >= 16'd2) && (r < rows_eff) && (c != '0)
                    && ((c_ext + 11'd2) <= cols_eff);
    pos.last      = (r == rows_eff - 16'd1) && (c_ext == cols_eff - 11'd2);

    // wrap at the row end; a position past a shrunk grid restarts at the origin
    if (c_inc >= cols_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= {1'b0, rows_eff}) ? '0 : r_inc[ROW_W-1:0];
    end else if (r >= rows_eff) begin
      col_nxt = '0;
      row_nxt = '0;
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/jfps_rowbuf.sv @@
// Two row buffers (row two above and row directly above) with write forwarding.
// Depends on jfps_pkg.
`default_nettype none
module jfps_rowbuf (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [jfps_pkg::COL_W-1:0] rd_col,
  input  wire logic                       wr_en,
  input  wire logic [jfps_pkg::COL_W-1:0] wr_col,
  input  wire jfps_pkg::sample_t          wr_sample,
  output jfps_pkg::nbr_t                  nbr
);
  import jfps_pkg::*;

  sample_t upper_mem [MAX_COLS];
  sample_t middle_mem [MAX_COLS];

  logic [COL_W-1:0] a_l, a_r;
  sample_t up_c_r, up_l_r, md_c_r, md_r_r;
  sample_t fwd_up_r, fwd_md_r;
  logic    hu_c_r, hu_l_r, hm_c_r, hm_r_r;
  sample_t mid_val;

  assign a_l = rd_col - COL_W'(1);
  assign a_r = rd_col + COL_W'(1);

  // middle[c] of the item in the pipe stage; it moves up into upper[c]
  assign mid_val = hm_c_r ? fwd_md_r : md_c_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_col]  <= mid_val;
      middle_mem[wr_col] <= wr_sample;
    end
  end

  // reads land at the same edge as the stage write, so that write is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_c_r   <= upper_mem[rd_col];
      up_l_r   <= upper_mem[a_l];
      md_c_r   <= middle_mem[rd_col];
      md_r_r   <= middle_mem[a_r];
      hu_c_r   <= wr_en && (wr_col == rd_col);
      hu_l_r   <= wr_en && (wr_col == a_l);
      hm_c_r   <= wr_en && (wr_col == rd_col);
      hm_r_r   <= wr_en && (wr_col == a_r);
      fwd_up_r <= mid_val;
      fwd_md_r <= wr_sample;
    end
  end

  assign nbr.left  = hu_l_r ? fwd_up_r : up_l_r;
  assign nbr.top   = hu_c_r ? fwd_up_r : up_c_r;
  assign nbr.right = hm_r_r ? fwd_md_r : md_r_r;
endmodule
`default_nettype wire

@@ rtl/jfps_out.sv @@
// Neighbour sum, quarter scaling and the result register with its handshake.
// Depends on jfps_pkg, jfps_out_if and the assertion macro header.
`default_nettype none
`include "jacobi_five_point_stencil_unit_defines.svh"
module jfps_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           s1_valid,
  input  wire jfps_pkg::stage_t s1,
  input  wire jfps_pkg::nbr_t nbr,
  output logic                advance,
  jfps_out_if.source          out_stream
);
  import jfps_pkg::*;

  logic                 out_valid_r;
  sample_t              new_value_r;
  logic [ROW_W-1:0]     point_row_r;
  logic [COL_W-1:0]     point_col_r;
  logic                 last_point_r;
  logic                 emit_now;
  logic signed [SAMPLE_W+1:0] sum;

  assign emit_now = s1_valid && s1.emit;
  // the stage moves unless it holds a result and the result register is stuck
  assign advance  = !emit_now || !out_valid_r || out_stream.ready;

  assign sum = {{2{nbr.left[SAMPLE_W-1]}}, nbr.left}
             + {{2{nbr.right[SAMPLE_W-1]}}, nbr.right}
             + {{2{nbr.top[SAMPLE_W-1]}}, nbr.top}
             + {{2{s1.sample[SAMPLE_W-1]}}, s1.sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit_now) begin
      new_value_r  <= sum[SAMPLE_W+1:2];  // arithmetic shift by two
      point_row_r  <= s1.point_row;
      point_col_r  <= s1.col;
      last_point_r <= s1.last;
    end
  end

  assign out_stream.valid      = out_valid_r;
  assign out_stream.new_value  = new_value_r;
  assign out_stream.point_row  = point_row_r;
  assign out_stream.point_col  = point_col_r;
  assign out_stream.last_point = last_point_r;

  `JFPS_ASSERT(a_empty_out_moves, !out_valid_r |-> advance, "stage stalled with empty output")
  `JFPS_ASSERT(a_full_holds, emit_now && out_valid_r && !out_stream.ready |-> !advance, "result overrun")
  `JFPS_ASSERT(a_rise_from_stage, $rose(out_valid_r) |-> $past(emit_now), "result without item")
endmodule
`default_nettype wire

@@ rtl/jacobi_five_point_stencil_unit.sv @@
// Top level of the Jacobi five-point stencil unit.
// Depends on jfps_pkg, jfps_in_if, jfps_out_if, jfps_pos, jfps_rowbuf, jfps_out.
//
//   channel     | dir | payload                                      | accept
//   in_stream   | in  | sample, grid_start                           | valid && ready
//   out_stream  | out | new_value, point_row, point_col, last_point  | valid && ready
//   cfg_*       | in  | cfg_index, cfg_data (grid_rows, grid_cols)   | cfg_we
//
// One item per cycle sustained; the item that completes a stencil passes the pipe
// stage (row buffer read) and then the sum into the result register.
// Synchronous active-low reset clears counters, valids and sets the grid to 256x256;
// the row buffers are not cleared. Input stalls only while the pipe stage holds a
// result and the result register is full and not taken.
`default_nettype none
module jacobi_five_point_stencil_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  jfps_in_if.sink                             in_stream,
  jfps_out_if.source                          out_stream,
  input  wire logic                           cfg_we,
  input  wire logic [jfps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jfps_pkg::CFG_W-1:0]     cfg_data
);
  import jfps_pkg::*;

  logic   advance;
  logic   accept;
  pos_t   pos;
  stage_t s1_r, s1_nxt;
  logic   s1_valid_r;
  nbr_t   nbr;

  assign in_stream.ready = advance;
  assign accept          = in_stream.valid && advance;

  jfps_pos u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .grid_start (in_stream.grid_start),
    .pos        (pos)
  );

  always_comb begin
    s1_nxt.sample    = in_stream.sample;
    s1_nxt.point_row = pos.point_row;
    s1_nxt.col       = pos.col;
    s1_nxt.emit      = pos.emit;
    s1_nxt.last      = pos.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r <= s1_nxt;
    end
  end

  jfps_rowbuf u_rowbuf (
    .clk       (clk),
    .rd_en     (advance),
    .rd_col    (pos.col),
    .wr_en     (advance && s1_valid_r),
    .wr_col    (s1_r.col),
    .wr_sample (s1_r.sample),
    .nbr       (nbr)
  );

  jfps_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1         (s1_r),
    .nbr        (nbr),
    .advance    (advance),
    .out_stream (out_stream)
  );
endmodule
`default_nettype wire
